@@ hdl/min_spanning_tree_matrix_core_assert.svh @@
// Assertion macros used by the checked RTL of the minimum spanning tree core.
`ifndef MIN_SPANNING_TREE_MATRIX_CORE_ASSERT_SVH
`define MIN_SPANNING_TREE_MATRIX_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSTM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/mstm_pkg.sv @@
// Package: types, widths and constants of the minimum spanning tree core.
`timescale 1ns / 1ps

package mstm_pkg;

   localparam int MAX_VERTICES_DEFAULT = 16;
   localparam int FIELD_LIMIT          = 16;
   localparam int VERTEX_W             = 4;
   localparam int WEIGHT_W             = 16;
   localparam int COUNT_W              = 4;
   localparam int TOTAL_W              = 20;
   localparam int VCOUNT_W             = 5;
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

   typedef logic [VERTEX_W-1:0] vertex_type;
   typedef logic [WEIGHT_W-1:0] weight_type;

   typedef enum logic [1:0] {
      OUTCOME_EDGE         = 2'd0,
      OUTCOME_DISCONNECTED = 2'd1,
      OUTCOME_SINGLE       = 2'd2
   } outcome_type;

   typedef struct packed {
      vertex_type row_index;
      vertex_type col_index;
      weight_type edge_weight;
      logic       final_entry;
   } req_payload_type;

   typedef struct packed {
      vertex_type           edge_from;
      vertex_type           edge_to;
      weight_type           edge_cost;
      logic [COUNT_W-1:0]   edge_number;
      logic [TOTAL_W-1:0]   total_cost;
      outcome_type          outcome;
      logic                 run_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [VCOUNT_W-1:0] vertex_count;
   } csr_payload_type;

   // Union-find control from the sequencer
   typedef struct packed {
      logic       clear;
      logic       find_start;
      vertex_type find_vertex;
      logic       link;
      vertex_type link_child;
      vertex_type link_parent;
   } uf_cmd_type;

   typedef struct packed {
      logic       find_done;
      vertex_type find_root;
   } uf_status_type;

   // Minimum search control and result
   typedef struct packed {
      logic       clear;
      logic       sample;
      vertex_type row;
      vertex_type col;
   } scan_cmd_type;

   typedef struct packed {
      logic       found;
      weight_type best;
      vertex_type row;
      vertex_type col;
   } scan_status_type;

endpackage

@@ hdl/mstm_chan_if.sv @@
// Interface: valid/ready channel carrying one payload type.
`timescale 1ns / 1ps

interface mstm_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/mstm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mstm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mstm_scan.sv @@
// Minimum search unit: one shared less-than compare applied to each streamed entry.
`timescale 1ns / 1ps

module mstm_scan (
   input  logic                      clock,
   input  logic                      reset,
   input  mstm_pkg::scan_cmd_type    cmd,
   input  mstm_pkg::weight_type      data,
   output mstm_pkg::scan_status_type status
);

   logic                 found_ff, found_in;
   mstm_pkg::weight_type best_ff, best_in;
   mstm_pkg::vertex_type row_ff, row_in;
   mstm_pkg::vertex_type col_ff, col_in;
   logic                 take;

   // Strict less-than keeps the first entry found on ties
   assign take = cmd.sample && (data != '0) && (!found_ff || (data < best_ff));

   always_comb begin
      found_in = found_ff;
      best_in  = best_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      if (cmd.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
         best_in  = data;
         row_in   = cmd.row;
         col_in   = cmd.col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_ff <= best_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
   end

   assign status.found = found_ff;
   assign status.best  = best_ff;
   assign status.row   = row_ff;
   assign status.col   = col_ff;

endmodule

@@ hdl/mstm_uf.sv @@
// Union-find parent file with a root walker that follows one link per cycle.
`timescale 1ns / 1ps

module mstm_uf (
   input  logic                    clock,
   input  logic                    reset,
   input  mstm_pkg::uf_cmd_type    cmd,
   output mstm_pkg::uf_status_type status
);

   logic                 root_ff   [mstm_pkg::FIELD_LIMIT];
   mstm_pkg::vertex_type parent_ff [mstm_pkg::FIELD_LIMIT];
   logic                 busy_ff, busy_in;
   mstm_pkg::vertex_type cur_ff, cur_in;
   logic                 at_root;

   assign at_root = root_ff[cur_ff];

   always_comb begin
      busy_in = busy_ff;
      cur_in  = cur_ff;
      if (cmd.find_start) begin
         busy_in = 1'b1;
         cur_in  = cmd.find_vertex;
      end else if (busy_ff) begin
         if (at_root) begin
            busy_in = 1'b0;
         end else begin
            cur_in = parent_ff[cur_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         for (int v = 0; v < mstm_pkg::FIELD_LIMIT; v++) begin
            root_ff[v] <= 1'b1;
         end
      end else begin
         busy_ff <= busy_in;
         if (cmd.clear) begin
            for (int v = 0; v < mstm_pkg::FIELD_LIMIT; v++) begin
               root_ff[v] <= 1'b1;
            end
         end else if (cmd.link) begin
            root_ff[cmd.link_child] <= 1'b0;
         end
      end
      cur_ff <= cur_in;
      if (cmd.link) begin
         parent_ff[cmd.link_child] <= cmd.link_parent;
      end
   end

   assign status.find_done = busy_ff && at_root;
   assign status.find_root = cur_ff;

endmodule

@@ hdl/min_spanning_tree_matrix_core.sv @@
// Top level: Kruskal minimum spanning tree over a loaded cost matrix.
`timescale 1ns / 1ps
`include "min_spanning_tree_matrix_core_assert.svh"
//
//   Channel   Role     Moves per transaction
//   req_bus   sink     one matrix entry (row, column, weight, last-entry flag)
//   rsp_bus   source   one tree edge or one status result
//   csr_bus   sink     vertex count n (1..16), taken at any cycle
//
// Matrix entries load at one per cycle; an entry without the last-entry flag
// gives no result. On the last entry a run starts and req_bus drops ready.
// Each pass of a run streams the n*n live entries through the shared compare,
// walks two root chains, joins if apart, and writes two removals, one pass per
// entry picked. Cost memory has one read and one write port; no clearing pass.
// A result waits in the output register; the run stalls only when a new result
// is due and the previous one has not been taken.
// Reset is synchronous, active high; it leaves n at 16 and the core idle.

module min_spanning_tree_matrix_core #(
   parameter int MAX_VERTICES = mstm_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   mstm_chan_if.sink   req_bus,
   mstm_chan_if.source rsp_bus,
   mstm_chan_if.sink   csr_bus
);

   localparam int ADDR_W = $clog2(MAX_VERTICES * MAX_VERTICES);
   localparam int NLIM   = (MAX_VERTICES < mstm_pkg::FIELD_LIMIT) ?
                           MAX_VERTICES : mstm_pkg::FIELD_LIMIT;
   localparam logic [mstm_pkg::VCOUNT_W-1:0] NLIM_V = mstm_pkg::VCOUNT_W'(NLIM);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_FIND_A,
      ST_FIND_B,
      ST_JOIN,
      ST_REM_AB,
      ST_REM_BA,
      ST_REPORT
   } state_type;

   state_type                         state_ff, state_in;
   logic [mstm_pkg::VCOUNT_W-1:0]     vcount_ff, vcount_in;
   mstm_pkg::vertex_type              n1_ff, n1_in;
   mstm_pkg::vertex_type              i_ff, i_in;
   mstm_pkg::vertex_type              j_ff, j_in;
   logic                              tag_valid_ff, tag_valid_in;
   mstm_pkg::vertex_type              tag_row_ff, tag_row_in;
   mstm_pkg::vertex_type              tag_col_ff, tag_col_in;
   logic [mstm_pkg::COUNT_W-1:0]      accepted_ff, accepted_in;
   logic [mstm_pkg::TOTAL_W-1:0]      sum_ff, sum_in;
   mstm_pkg::vertex_type              ra_ff, ra_in;
   mstm_pkg::vertex_type              rb_ff, rb_in;
   mstm_pkg::outcome_type             outcome_ff, outcome_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   mstm_pkg::rsp_payload_type         rsp_data_ff, rsp_data_in;

   logic [mstm_pkg::VCOUNT_W-1:0]     vc_sat;
   mstm_pkg::vertex_type              n1_now;
   logic                              in_range;
   logic                              slot_free;
   logic                              rsp_load;
   logic [mstm_pkg::COUNT_W-1:0]      accepted_inc;
   logic [mstm_pkg::TOTAL_W-1:0]      sum_inc;

   logic                              ram_we;
   mstm_pkg::vertex_type              wr_row, wr_col;
   mstm_pkg::weight_type              ram_wd;
   logic [ADDR_W-1:0]                 ram_wa, ram_ra;
   mstm_pkg::weight_type              ram_rd;

   mstm_pkg::uf_cmd_type              uf_cmd;
   mstm_pkg::uf_status_type           uf_status;
   mstm_pkg::scan_cmd_type            scan_cmd;
   mstm_pkg::scan_status_type         scan_status;

   // Cost store, row-major at row * MAX_VERTICES + column
   mstm_ram #(
      .WIDTH (mstm_pkg::WEIGHT_W),
      .DEPTH (MAX_VERTICES * MAX_VERTICES)
   ) u_cost_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   mstm_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .cmd    (scan_cmd),
      .data   (ram_rd),
      .status (scan_status)
   );

   mstm_uf u_uf (
      .clock  (clock),
      .reset  (reset),
      .cmd    (uf_cmd),
      .status (uf_status)
   );

   // Clamp the vertex count to 1..NLIM
   always_comb begin
      if (vcount_ff == '0) begin
         vc_sat = mstm_pkg::VCOUNT_W'(1);
      end else if (vcount_ff > NLIM_V) begin
         vc_sat = NLIM_V;
      end else begin
         vc_sat = vcount_ff;
      end
   end
   assign n1_now = mstm_pkg::VERTEX_W'(vc_sat - mstm_pkg::VCOUNT_W'(1));

   assign in_range = (int'(req_bus.payload.row_index) < MAX_VERTICES) &&
                     (int'(req_bus.payload.col_index) < MAX_VERTICES);

   assign slot_free    = !rsp_valid_ff || rsp_bus.ready;
   assign accepted_inc = accepted_ff + mstm_pkg::COUNT_W'(1);
   assign sum_inc      = sum_ff + mstm_pkg::TOTAL_W'(scan_status.best);

   assign ram_ra = ADDR_W'(ADDR_W'(i_ff) * ADDR_W'(MAX_VERTICES) + ADDR_W'(j_ff));
   assign ram_wa = ADDR_W'(ADDR_W'(wr_row) * ADDR_W'(MAX_VERTICES) + ADDR_W'(wr_col));

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      vcount_in    = vcount_ff;
      n1_in        = n1_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      tag_valid_in = 1'b0;
      tag_row_in   = i_ff;
      tag_col_in   = j_ff;
      accepted_in  = accepted_ff;
      sum_in       = sum_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      outcome_in   = outcome_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_load     = 1'b0;

      ram_we = 1'b0;
      wr_row = scan_status.row;
      wr_col = scan_status.col;
      ram_wd = '0;

      uf_cmd   = '0;
      scan_cmd = '0;
      scan_cmd.sample = tag_valid_ff;
      scan_cmd.row    = tag_row_ff;
      scan_cmd.col    = tag_col_ff;

      // Drop the held result once taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_bus.valid) begin
         vcount_in = csr_bus.payload.vertex_count;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               wr_row = req_bus.payload.row_index;
               wr_col = req_bus.payload.col_index;
               ram_wd = req_bus.payload.edge_weight;
               ram_we = in_range;
               if (req_bus.payload.final_entry) begin
                  n1_in       = n1_now;
                  accepted_in = '0;
                  sum_in      = '0;
                  uf_cmd.clear = 1'b1;
                  if (n1_now == '0) begin
                     outcome_in = mstm_pkg::OUTCOME_SINGLE;
                     state_in   = ST_REPORT;
                  end else begin
                     scan_cmd.clear = 1'b1;
                     i_in     = '0;
                     j_in     = '0;
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            // Issue one read a cycle; its tag follows the RAM latency
            tag_valid_in = 1'b1;
            if (j_ff == n1_ff) begin
               j_in = '0;
               if (i_ff == n1_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + mstm_pkg::VERTEX_W'(1);
               end
            end else begin
               j_in = j_ff + mstm_pkg::VERTEX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!scan_status.found) begin
               outcome_in = mstm_pkg::OUTCOME_DISCONNECTED;
               state_in   = ST_REPORT;
            end else begin
               uf_cmd.find_start  = 1'b1;
               uf_cmd.find_vertex = scan_status.row;
               state_in           = ST_FIND_A;
            end
         end
         ST_FIND_A: begin
            if (uf_status.find_done) begin
               ra_in              = uf_status.find_root;
               uf_cmd.find_start  = 1'b1;
               uf_cmd.find_vertex = scan_status.col;
               state_in           = ST_FIND_B;
            end
         end
         ST_FIND_B: begin
            if (uf_status.find_done) begin
               rb_in    = uf_status.find_root;
               state_in = ST_JOIN;
            end
         end
         ST_JOIN: begin
            if (ra_ff == rb_ff) begin
               state_in = ST_REM_AB;
            end else if (slot_free) begin
               uf_cmd.link        = 1'b1;
               uf_cmd.link_child  = rb_ff;
               uf_cmd.link_parent = ra_ff;
               accepted_in        = accepted_inc;
               sum_in             = sum_inc;
               rsp_load           = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_data_in.edge_from   = scan_status.row;
               rsp_data_in.edge_to     = scan_status.col;
               rsp_data_in.edge_cost   = scan_status.best;
               rsp_data_in.edge_number = accepted_inc;
               rsp_data_in.total_cost  = sum_inc;
               rsp_data_in.outcome     = mstm_pkg::OUTCOME_EDGE;
               rsp_data_in.run_end     = (accepted_inc == n1_ff);
               state_in = ST_REM_AB;
            end
         end
         ST_REM_AB: begin
            ram_we   = 1'b1;
            state_in = ST_REM_BA;
         end
         ST_REM_BA: begin
            // Remove the mirrored entry, then end the run or scan again
            wr_row = scan_status.col;
            wr_col = scan_status.row;
            ram_we = 1'b1;
            if (accepted_ff == n1_ff) begin
               state_in = ST_IDLE;
            end else begin
               scan_cmd.clear = 1'b1;
               i_in     = '0;
               j_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_REPORT: begin
            if (slot_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in.edge_from   = '0;
               rsp_data_in.edge_to     = '0;
               rsp_data_in.edge_cost   = '0;
               rsp_data_in.edge_number = accepted_ff;
               rsp_data_in.total_cost  = sum_ff;
               rsp_data_in.outcome     = outcome_ff;
               rsp_data_in.run_end     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vcount_ff    <= mstm_pkg::VCOUNT_RESET;
         tag_valid_ff <= 1'b0;
         accepted_ff  <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vcount_ff    <= vcount_in;
         tag_valid_ff <= tag_valid_in;
         accepted_ff  <= accepted_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n1_ff       <= n1_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      tag_row_ff  <= tag_row_in;
      tag_col_ff  <= tag_col_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      outcome_ff  <= outcome_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Join only vertices from different trees
   `MSTM_ASSERT_NOW(a_link_roots_differ, clock, reset, uf_cmd.link, ra_ff != rb_ff, "link within one tree")
   // Every join counts exactly one edge
   `MSTM_ASSERT_NEXT(a_link_counts, clock, reset, uf_cmd.link, accepted_ff == $past(accepted_ff) + 4'd1, "edge count off after join")
   // Never overwrite a result not yet taken
   `MSTM_ASSERT_NOW(a_result_slot, clock, reset, rsp_load, !rsp_valid_ff || rsp_bus.ready, "held result overwritten")
   // A run never counts more edges than its tree needs
   `MSTM_ASSERT_NOW(a_count_bound, clock, reset, state_ff != ST_IDLE, accepted_ff <= n1_ff, "edge count beyond n-1")

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the minimum spanning tree core: matrix-load stimulus, Kruskal predictor, checker.
`timescale 1ns / 1ps

module tb;

   localparam int VERTICES      = mstm_pkg::MAX_VERTICES_DEFAULT;
   localparam int ITEM_TARGET   = 470;
   // Covers one full pass at n = 16, with some margin on top.
   localparam int SETTLE_CYCLES = 340;
   localparam int LONG_HOLD     = 4000;
   localparam int CYCLE_LIMIT   = 2_000_000;

   typedef enum int {
      SHAPE_DENSE,
      SHAPE_SPARSE,
      SHAPE_TIED,
      SHAPE_SPLIT,
      SHAPE_MIRRORED
   } matrix_shape_type;

   logic clock;
   logic reset;

   mstm_chan_if #(.payload_type(mstm_pkg::req_payload_type)) req_bus ();
   mstm_chan_if #(.payload_type(mstm_pkg::rsp_payload_type)) rsp_bus ();
   mstm_chan_if #(.payload_type(mstm_pkg::csr_payload_type)) csr_bus ();

   min_spanning_tree_matrix_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Matrix entries waiting to be offered, and tree results still owed by the core.
   mstm_pkg::req_payload_type entry_queue[$];
   mstm_pkg::rsp_payload_type tree_results_due[$];

   // Predictor's own copy of the core's state.
   logic [mstm_pkg::WEIGHT_W-1:0] cost_copy [VERTICES*VERTICES];
   int unsigned                   parent_of [VERTICES];
   bit                            is_root   [VERTICES];
   logic [mstm_pkg::VCOUNT_W-1:0] vertex_count_reg;

   // Generator's view: which store entries have been (or will be) written.
   bit          planned [VERTICES*VERTICES];
   int unsigned plan_n;

   // Handshake and idling state of the driver and the receiver.
   bit          req_taken;
   bit          steady;
   bit          hold_request;
   int unsigned send_gap;
   int unsigned stall_left;
   int unsigned hold_left;

   // Run statistics.
   int unsigned mismatches;
   int unsigned entries_sent;
   int unsigned runs_started;
   int unsigned edges_seen;
   int unsigned status_seen;
   int unsigned cfg_writes;
   int unsigned long_holds;
   int unsigned cycle_count;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Map the raw register value to the vertex count actually used: zero acts
   // as a single vertex and anything above the matrix size saturates.
   function automatic int unsigned effective_n(logic [mstm_pkg::VCOUNT_W-1:0] value);
      if (value == 0)
         return 1;
      if (value > VERTICES)
         return VERTICES;
      return value;
   endfunction

   // Follow parent links to the root, bounded by n steps.
   function automatic int unsigned chain_root(int unsigned v, int unsigned n);
      int unsigned steps;
      steps = 0;
      while (!is_root[v] && steps < n) begin
         v = parent_of[v];
         steps++;
      end
      return v;
   endfunction

   // Store one accepted entry; on the last entry grow the tree Kruskal style
   // and queue every result the run should produce.
   function automatic void predict_spanning_tree(mstm_pkg::req_payload_type e);
      int unsigned                   n;
      int unsigned                   joined;
      int unsigned                   a;
      int unsigned                   b;
      int unsigned                   ra;
      int unsigned                   rb;
      logic [mstm_pkg::WEIGHT_W-1:0] best;
      logic [mstm_pkg::WEIGHT_W-1:0] c;
      logic [mstm_pkg::TOTAL_W-1:0]  sum;
      bit                            found;
      mstm_pkg::rsp_payload_type     r;

      cost_copy[{e.row_index, e.col_index}] = e.edge_weight;
      if (!e.final_entry)
         return;

      n = effective_n(vertex_count_reg);
      for (int v = 0; v < VERTICES; v++) begin
         parent_of[v] = 0;
         is_root[v]   = 1'b1;
      end
      joined = 0;
      sum    = '0;

      if (n == 1) begin
         r         = '0;
         r.outcome = mstm_pkg::OUTCOME_SINGLE;
         r.run_end = 1'b1;
         tree_results_due.push_back(r);
         return;
      end

      while (joined < n - 1) begin
         found = 1'b0;
         best  = '0;
         a     = 0;
         b     = 0;
         // Row-major scan, strict less-than: the first minimum found wins.
         for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
               c = cost_copy[i*VERTICES + j];
               if (c != 0 && (!found || c < best)) begin
                  found = 1'b1;
                  best  = c;
                  a     = i;
                  b     = j;
               end
            end
         end
         if (!found) begin
            r             = '0;
            r.edge_number = joined[mstm_pkg::COUNT_W-1:0];
            r.total_cost  = sum;
            r.outcome     = mstm_pkg::OUTCOME_DISCONNECTED;
            r.run_end     = 1'b1;
            tree_results_due.push_back(r);
            return;
         end
         ra = chain_root(a, n);
         rb = chain_root(b, n);
         if (ra != rb) begin
            parent_of[rb] = ra;
            is_root[rb]   = 1'b0;
            joined++;
            sum           = sum + best;
            r.edge_from   = mstm_pkg::vertex_type'(a);
            r.edge_to     = mstm_pkg::vertex_type'(b);
            r.edge_cost   = best;
            r.edge_number = joined[mstm_pkg::COUNT_W-1:0];
            r.total_cost  = sum;
            r.outcome     = mstm_pkg::OUTCOME_EDGE;
            r.run_end     = (joined == n - 1);
            tree_results_due.push_back(r);
         end
         // Self loops and cycle-closing entries are dropped just the same.
         cost_copy[a*VERTICES + b] = '0;
         cost_copy[b*VERTICES + a] = '0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Mostly back to back, some short gaps, the odd long one.
   function automatic int unsigned pick_idle_length();
      int unsigned r;
      if (steady)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Weight mix: absent edges, the two extremes, small values for ties, full range.
   function automatic int unsigned pick_weight();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 1;
         2:       return 65535;
         3:       return $urandom_range(1, 8);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   task automatic push_entry(int unsigned row, int unsigned col, int unsigned w, bit last);
      mstm_pkg::req_payload_type e;
      e.row_index   = mstm_pkg::vertex_type'(row);
      e.col_index   = mstm_pkg::vertex_type'(col);
      e.edge_weight = mstm_pkg::weight_type'(w);
      e.final_entry = last;
      entry_queue.push_back(e);
      planned[row*VERTICES + col] = 1'b1;
      entries_sent++;
      if (last)
         runs_started++;
   endtask

   // Load a whole n-by-n matrix in row-major order; the last entry starts the run.
   task automatic load_matrix(int unsigned n, matrix_shape_type shape);
      int unsigned w [VERTICES][VERTICES];
      int unsigned cut;
      cut = $urandom_range(1, n - 1);
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            case (shape)
               SHAPE_SPARSE:   w[i][j] = ($urandom_range(0, 9) < 7) ? 0 : pick_weight();
               SHAPE_TIED:     w[i][j] = $urandom_range(0, 3);
               // No weight crosses the cut, so the graph falls apart.
               SHAPE_SPLIT:    w[i][j] = ((i < cut) == (j < cut)) ? pick_weight() : 0;
               SHAPE_MIRRORED: w[i][j] = (j < i) ? w[j][i] : pick_weight();
               default:        w[i][j] = ($urandom_range(0, 9) == 0) ? 0 : pick_weight();
            endcase
            push_entry(i, j, w[i][j], (i == n - 1) && (j == n - 1));
         end
      end
   endtask

   // Rewrite a few entries (some beyond n), fill any hole inside the n-by-n
   // region so that no unwritten entry is ever scanned, then start a run.
   task automatic patch_matrix(int unsigned n, int unsigned count);
      int unsigned row;
      int unsigned col;
      repeat (count) begin
         if ($urandom_range(0, 4) == 0) begin
            row = $urandom_range(0, VERTICES - 1);
            col = $urandom_range(0, VERTICES - 1);
         end else begin
            row = $urandom_range(0, n - 1);
            col = $urandom_range(0, n - 1);
         end
         push_entry(row, col, pick_weight(), 1'b0);
      end
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            if (!planned[i*VERTICES + j])
               push_entry(i, j, pick_weight(), 1'b0);
      push_entry($urandom_range(0, VERTICES - 1), $urandom_range(0, VERTICES - 1),
                 pick_weight(), 1'b1);
   endtask

   // Hold the sender until every queued entry is taken and every result is in.
   task automatic drain_results();
      do
         @(posedge clock);
      while (entry_queue.size() != 0 || tree_results_due.size() != 0);
   endtask

   // Write the vertex count only with the core idle: drain, let the last
   // removals finish, then run one transaction on the register channel.
   task automatic set_vertex_count(logic [mstm_pkg::VCOUNT_W-1:0] value);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_bus.valid   <= 1'b1;
      csr_bus.payload <= mstm_pkg::csr_payload_type'(value);
      do
         @(posedge clock);
      while (csr_bus.ready !== 1'b1);
      vertex_count_reg = value;
      plan_n           = effective_n(value);
      cfg_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: offer queued entries at the falling edge, hold until taken.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_bus.valid && req_bus.ready) begin
         req_taken = 1'b1;
         void'(entry_queue.pop_front());
         predict_spanning_tree(req_bus.payload);
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (req_taken)
            send_gap = pick_idle_length();
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (entry_queue.size() > 0) begin
            req_bus.valid   <= 1'b1;
            req_bus.payload <= entry_queue[0];
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls plus one long hold-off on request.
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = LONG_HOLD - 1;
         long_holds++;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         stall_left = pick_idle_length();
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor: compare each result transaction with the oldest one owed.
   always @(posedge clock) begin
      mstm_pkg::rsp_payload_type want;
      mstm_pkg::rsp_payload_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         if (tree_results_due.size() == 0) begin
            $error("unexpected result: from %0d to %0d cost %0d outcome %0d",
                   got.edge_from, got.edge_to, got.edge_cost, got.outcome);
            mismatches++;
         end else begin
            want = tree_results_due.pop_front();
            check_field("edge_from",   want.edge_from,   got.edge_from);
            check_field("edge_to",     want.edge_to,     got.edge_to);
            check_field("edge_cost",   want.edge_cost,   got.edge_cost);
            check_field("edge_number", want.edge_number, got.edge_number);
            check_field("total_cost",  want.total_cost,  got.total_cost);
            check_field("outcome",     want.outcome,     got.outcome);
            check_field("run_end",     want.run_end,     got.run_end);
            if (want.outcome == mstm_pkg::OUTCOME_EDGE)
               edges_seen++;
            else
               status_seen++;
         end
      end
   end

   // Watchdog: give up on a hung core.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------

   initial begin
      int unsigned pick;

      // Drive every input to a known level from time zero.
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.payload = '0;
      vertex_count_reg = mstm_pkg::VCOUNT_RESET;
      plan_n           = effective_n(mstm_pkg::VCOUNT_RESET);
      steady           = 1'b0;
      hold_request     = 1'b0;
      send_gap         = 0;
      stall_left       = 0;
      hold_left        = 0;
      for (int k = 0; k < VERTICES*VERTICES; k++) begin
         cost_copy[k] = '0;
         planned[k]   = 1'b0;
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single vertex, with the register at one and at zero.
      set_vertex_count(5'd1);
      push_entry(0, 0, 65535, 1'b1);
      set_vertex_count(5'd0);
      push_entry(15, 15, 16'hA5A5, 1'b1);

      // Two vertices: the lightest edge completes the tree at once; a second
      // run finds the mirrored heavy entry already removed and reports a
      // disconnected graph with no edges.
      set_vertex_count(5'd2);
      push_entry(0, 0, 0, 1'b0);
      push_entry(0, 1, 65535, 1'b0);
      push_entry(1, 0, 1, 1'b0);
      push_entry(1, 1, 0, 1'b1);
      push_entry(1, 0, 0, 1'b1);

      // Three vertices: a self loop picked first and rejected, then a tie
      // that the earlier entry in row-major order must win.
      set_vertex_count(5'd3);
      push_entry(0, 0, 1, 1'b0);
      push_entry(0, 1, 5, 1'b0);
      push_entry(0, 2, 5, 1'b0);
      push_entry(1, 0, 0, 1'b0);
      push_entry(1, 1, 0, 1'b0);
      push_entry(1, 2, 7, 1'b0);
      push_entry(2, 0, 0, 1'b0);
      push_entry(2, 1, 65535, 1'b0);
      push_entry(2, 2, 0, 1'b1);
      // Rerun on what is left: one edge, then the graph runs dry.
      push_entry(2, 2, 0, 1'b1);

      // Full sixteen-vertex load; hold the receiver off long enough that the
      // run stalls on its output and the next run's entries pile up behind.
      set_vertex_count(5'd16);
      load_matrix(16, SHAPE_DENSE);
      hold_request = 1'b1;
      patch_matrix(16, 8);
      drain_results();

      // Top of the register range saturates to sixteen.
      set_vertex_count(5'd31);
      steady = 1'b1;
      patch_matrix(16, 12);
      steady = 1'b0;

      // Random runs: small matrices loaded whole, others patched in place.
      while (entries_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 1) == 0) begin
            pick = $urandom_range(0, 19);
            case (pick)
               0:       set_vertex_count(5'd0);
               1:       set_vertex_count(5'd1);
               2:       set_vertex_count(5'($urandom_range(17, 31)));
               3, 4:    set_vertex_count(5'($urandom_range(7, 16)));
               default: set_vertex_count(5'($urandom_range(2, 6)));
            endcase
         end
         steady = ($urandom_range(0, 4) == 0);
         if (plan_n >= 2 && plan_n <= 6 && $urandom_range(0, 2) != 0)
            load_matrix(plan_n, matrix_shape_type'($urandom_range(0, 4)));
         else
            patch_matrix(plan_n, $urandom_range(1, 8));
      end
      steady = 1'b0;

      // Let the last run finish and the core settle before judging.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d matrix entries in %0d runs across %0d vertex-count writes.",
               entries_sent, runs_started, cfg_writes);
      $display("Checked %0d tree edges and %0d status results; %0d long receiver hold.",
               edges_seen, status_seen, long_holds);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/mstm_pkg.sv
hdl/mstm_chan_if.sv
hdl/mstm_ram.sv
hdl/mstm_scan.sv
hdl/mstm_uf.sv
hdl/min_spanning_tree_matrix_core.sv
tb/sv/tb.sv
